/* hw/rtl/sh176_pkg.sv */
// Shared types, constants and round functions for the sponge_hash_176 block.
// No dependencies; imported by every module of the block.
package sh176_pkg;

	localparam int STATE_BYTES  = 22;
	localparam int STATE_BITS   = STATE_BYTES * 8;
	localparam int DIGEST_BYTES = 20;
	localparam int ROUND_COUNT  = 90;
	localparam int RND_W        = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
	localparam int RC_IDX_W     = 7;
	localparam int DIG_IDX_W    = $clog2(STATE_BYTES);
	localparam int PERM_STRIDE  = STATE_BITS / 4;
	localparam int QUEUE_DEPTH  = 2;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] PAD_BYTE  = 8'h80;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	// One block to absorb; squeeze marks the padded final block.
	typedef struct packed {
		logic [7:0] first;
		logic [7:0] second;
		logic       squeeze;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_SQUEEZE
	} core_state_t;

	function automatic logic [3:0] sbox4(input logic [3:0] x);
		logic [3:0] y;
		unique case (x)
			4'h0: y = 4'hC;
			4'h1: y = 4'h5;
			4'h2: y = 4'h6;
			4'h3: y = 4'hB;
			4'h4: y = 4'h9;
			4'h5: y = 4'h0;
			4'h6: y = 4'hA;
			4'h7: y = 4'hD;
			4'h8: y = 4'h3;
			4'h9: y = 4'hE;
			4'hA: y = 4'hF;
			4'hB: y = 4'h8;
			4'hC: y = 4'h4;
			4'hD: y = 4'h7;
			4'hE: y = 4'h1;
			default: y = 4'h2;
		endcase
		return y;
	endfunction

	// Per-round constant XORed into the top state byte; zero past the table.
	function automatic logic [7:0] round_const(input logic [RC_IDX_W-1:0] idx);
		logic [7:0] c;
		unique case (idx)
			7'd0:  c = 8'h75;
			7'd1:  c = 8'h3A;
			7'd2:  c = 8'h1D;
			7'd3:  c = 8'h0E;
			7'd4:  c = 8'h07;
			7'd5:  c = 8'h03;
			7'd6:  c = 8'h01;
			7'd16: c = 8'h08;
			7'd17: c = 8'h04;
			7'd18: c = 8'h02;
			7'd19: c = 8'h01;
			7'd32: c = 8'h10;
			7'd33: c = 8'h08;
			7'd34: c = 8'h04;
			7'd35: c = 8'h02;
			7'd36: c = 8'h01;
			7'd48: c = 8'h20;
			7'd49: c = 8'h10;
			7'd50: c = 8'h08;
			7'd51: c = 8'h04;
			7'd52: c = 8'h02;
			7'd53: c = 8'h01;
			7'd64: c = 8'h40;
			7'd65: c = 8'h20;
			7'd66: c = 8'h10;
			7'd67: c = 8'h08;
			7'd68: c = 8'h04;
			7'd69: c = 8'h02;
			7'd70: c = 8'h01;
			7'd81: c = 8'h40;
			7'd82: c = 8'h20;
			7'd83: c = 8'h10;
			7'd84: c = 8'h08;
			7'd85: c = 8'h04;
			7'd86: c = 8'h02;
			7'd87: c = 8'h01;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/sh176_front.sv */
// Input side of sponge_hash_176: pairs message bytes into blocks and adds padding.
// Depends on sh176_pkg; feeds block commands into sh176_queue.
module sh176_front
	import sh176_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] data_byte,
	input  logic       carries_byte,
	input  logic       final_item,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       push,
	output cmd_t       push_cmd,
	input  logic       q_full
);

	logic [7:0] held_byte_q;
	logic       held_valid_q;
	logic       pend_valid_q;
	cmd_t       pend_cmd_q;

	logic       accept;
	logic       has_a;
	logic       two_cmds;
	cmd_t       cmd_a;
	cmd_t       cmd_pad;
	logic [7:0] hb_d;
	logic       hv_d;

	assign in_ready = !pend_valid_q && !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		has_a   = 1'b0;
		cmd_a   = '{first: held_byte_q, second: data_byte, squeeze: 1'b0};
		hb_d    = held_byte_q;
		hv_d    = held_valid_q;
		if (carries_byte && held_valid_q) begin
			has_a = 1'b1;
			hv_d  = 1'b0;
			hb_d  = ZERO_BYTE;
		end else if (carries_byte) begin
			hv_d = 1'b1;
			hb_d = data_byte;
		end
		if (hv_d) begin
			cmd_pad = '{first: hb_d, second: PAD_BYTE, squeeze: 1'b1};
		end else begin
			cmd_pad = '{first: PAD_BYTE, second: ZERO_BYTE, squeeze: 1'b1};
		end
		two_cmds = has_a && final_item;
		if (final_item) begin
			hv_d = 1'b0;
			hb_d = ZERO_BYTE;
		end
	end

	always_comb begin
		if (pend_valid_q) begin
			push     = !q_full;
			push_cmd = pend_cmd_q;
		end else begin
			push     = accept && (has_a || final_item);
			push_cmd = has_a ? cmd_a : cmd_pad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				held_byte_q  <= hb_d;
				held_valid_q <= hv_d;
			end
			if (accept && two_cmds) begin
				pend_valid_q <= 1'b1;
			end else if (pend_valid_q && !q_full) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && two_cmds) begin
			pend_cmd_q <= cmd_pad;
		end
	end

endmodule

/* hw/rtl/sh176_queue.sv */
// Short command queue between the front and the permutation core.
// Depends on sh176_pkg for cmd_t and the queue depth.
module sh176_queue
	import sh176_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full    = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCNT_W'(push && !full) - QCNT_W'(pop && !empty);
		end
	end

endmodule

/* hw/rtl/sh176_core.sv */
// Permutation core: absorbs blocks, runs one round per cycle, squeezes the digest.
// Depends on sh176_pkg for the S-box, round constants and state machine type.
module sh176_core
	import sh176_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       pop_cmd,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last
);

	core_state_t st_q, st_d;

	logic [STATE_BITS-1:0] state_q;
	logic [STATE_BITS-1:0] sub_w;
	logic [STATE_BITS-1:0] perm_w;
	logic [STATE_BITS-1:0] round_w;
	logic [RND_W-1:0]      rnd_q;
	logic [DIG_IDX_W-1:0]  dig_idx_q;
	logic                  squeeze_q;
	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_last_q;

	logic load_out;
	logic last_round;
	logic last_dig;

	assign last_round = (rnd_q == RND_W'(ROUND_COUNT - 1));
	assign last_dig   = (dig_idx_q == DIG_IDX_W'(DIGEST_BYTES - 1));

	// One round: nibble substitution, bit spread by four, constant into top byte.
	always_comb begin
		for (int n = 0; n < STATE_BITS / 4; n++) begin
			sub_w[n*4 +: 4] = sbox4(state_q[n*4 +: 4]);
		end
		for (int j = 0; j < STATE_BITS; j++) begin
			perm_w[(j % 4) * PERM_STRIDE + j / 4] = sub_w[j];
		end
		round_w = perm_w;
		round_w[STATE_BITS-8 +: 8] = perm_w[STATE_BITS-8 +: 8]
			^ round_const(RC_IDX_W'(rnd_q));
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (!q_empty) begin
					st_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (last_round) begin
					st_d = squeeze_q ? ST_SQUEEZE : ST_IDLE;
				end
			end
			ST_SQUEEZE: begin
				if (load_out && last_dig) begin
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		load_out = 1'b0;
		unique case (st_q)
			ST_IDLE:    pop      = !q_empty;
			ST_ROUND:   ;
			ST_SQUEEZE: load_out = !out_valid_q || out_ready;
			default:    ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			state_q     <= '0;
			rnd_q       <= '0;
			dig_idx_q   <= '0;
			squeeze_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (pop) begin
				state_q[7:0]  <= state_q[7:0] ^ pop_cmd.first;
				state_q[15:8] <= state_q[15:8] ^ pop_cmd.second;
				squeeze_q     <= pop_cmd.squeeze;
				rnd_q         <= '0;
				dig_idx_q     <= '0;
			end else if (st_q == ST_ROUND) begin
				state_q <= round_w;
				rnd_q   <= rnd_q + 1'b1;
			end else if (load_out) begin
				dig_idx_q <= dig_idx_q + 1'b1;
				if (last_dig) begin
					state_q <= '0;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_byte_q <= state_q[dig_idx_q*8 +: 8];
			out_last_q <= last_dig;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

	// A block is only taken from the queue while no permutation or squeeze runs.
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (st_q == ST_IDLE))
		else $error("block popped while core busy");

	// Squeeze finishes with a cleared sponge state.
	a_clear_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && last_dig) |=> (state_q == '0))
		else $error("state not cleared after digest");

	// The digest index never runs past the last digest byte while squeezing.
	a_dig_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_SQUEEZE) |-> (dig_idx_q <= DIG_IDX_W'(DIGEST_BYTES - 1)))
		else $error("digest index out of range");

	// Only a squeeze block leads from rounds into the squeeze state.
	a_squeeze_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND && last_round) |=> ((st_q == ST_SQUEEZE) == $past(squeeze_q)))
		else $error("wrong state after last round");

endmodule

/* hw/rtl/sponge_hash_176.sv */
// Top level of the byte-serial sponge hash over a 176-bit state.
// Depends on sh176_pkg, sh176_front, sh176_queue and sh176_core.
//
// Message bytes come in one request at a time. The front pairs them into
// two-byte blocks, pads the message end with 0x80 (closing an odd block, or
// forming its own block 0x80,0x00) and queues block commands, two deep. The
// core loads a block into state bytes 0 and 1 and then runs 90 rounds, one
// per cycle. The final block is followed by 20 digest requests, state byte 0
// first, one per cycle while the sink takes them, with tlast on the twentieth;
// the state is then cleared for the next message. The front keeps taking
// bytes while the queue has room and no padding block waits to be pushed,
// and the registered output lets the core pick up the next block as soon as
// the last digest byte has been loaded.
module sponge_hash_176
	import sh176_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0] s_axis_tuser,   // [0] carries_byte
	input  logic       s_axis_tlast,   // final_item
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] hash_byte
	output logic       m_axis_tlast    // last_of_digest
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	cmd_t pop_cmd;
	logic q_empty;

	// Front: byte pairing and padding.
	sh176_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (s_axis_tdata),
		.carries_byte (s_axis_tuser[0]),
		.final_item   (s_axis_tlast),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.push         (push),
		.push_cmd     (push_cmd),
		.q_full       (q_full)
	);

	// Decouples the front from the long-running permutation.
	sh176_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (q_empty)
	);

	// Back: absorb, rounds, squeeze.
	sh176_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_cmd   (pop_cmd),
		.q_empty   (q_empty),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule
